// ===== hdl/ple_pkg.sv =====
// ---------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Sizes, operation and status codes, cell control types.
// ---------------------------------------------------------------------------
package ple_pkg;

    // list size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_DUMP      = 3'd7
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // what a cell loads on the next edge
    typedef enum logic [2:0] {
        CM_HOLD  = 3'd0,
        CM_LOAD  = 3'd1,
        CM_LEFT  = 3'd2,
        CM_RIGHT = 3'd3,
        CM_HEAD  = 3'd4
    } t_cell_mode;

    // values broadcast to every cell
    typedef struct packed {
        logic signed [DATA_W-1:0] load_value;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] head;
    } t_cell_bus;

endpackage

// ===== hdl/positional_list_engine_core.sv =====
// ---------------------------------------------------------------------------
// positional_list_engine_core: ordered list of signed 32-bit values
// Insert, delete, search and dump on a row of shift cells.
// ---------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Every operation
// but dump gives one result beat on the cycle after it is taken, and a new
// operation may be taken in that same cycle, so these run at one per cycle.
// A dump of a non-empty list gives one beat per element, front first, on
// consecutive cycles starting the cycle after it is taken, with o_last_item
// on the final beat; busy stays high until that final beat is registered.
// The dump rotates the cell row once round, which leaves the list as it
// was. Result beats last one cycle and cannot be held off by the receiver.
module positional_list_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ple_pkg::OP_W-1:0]          i_opcode,
    input  logic [ple_pkg::POS_W-1:0]         i_position,
    input  logic signed [ple_pkg::DATA_W-1:0] i_data_value,
    input  logic signed [ple_pkg::DATA_W-1:0] i_search_key,
    output logic                              o_strobe,
    output logic [ple_pkg::ST_W-1:0]          o_status,
    output logic                              o_found,
    output logic signed [ple_pkg::DATA_W-1:0] o_element_value,
    output logic                              o_last_item,
    output logic [ple_pkg::LEN_W-1:0]         o_list_length
);
    import ple_pkg::*;

    // control state
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dump, n_dump;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_strobe, n_strobe;

    // result registers
    t_status                  r_status, n_status;
    logic                     r_found, n_found;
    logic signed [DATA_W-1:0] r_elem, n_elem;
    logic                     r_last, n_last;
    logic [LEN_W-1:0]         r_len, n_len;

    // decode
    t_opcode          op;
    logic             accept;
    logic             do_ins, do_del;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] last_slot;
    logic             is_empty, is_full;
    t_status          op_status;
    logic             any_match;
    logic             dump_beat;
    logic [CNT_W-1:0] beat_idx;
    logic             beat_last;

    // cell row
    t_cell_bus                cell_bus;
    t_cell_mode               cell_mode  [CAPACITY];
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;

    assign op        = t_opcode'(i_opcode);
    assign busy      = r_dump;
    assign accept    = start && !r_dump;
    assign pos_ext   = CNT_W'(i_position);
    assign last_slot = r_count - CNT_W'(1);
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count >= CNT_W'(CAPACITY));

    // search hit over the occupied cells
    always_comb begin
        any_match = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_match[i] && (CNT_W'(i) < r_count)) begin
                any_match = 1'b1;
            end
        end
    end

    // operation decode: status, slot and list change
    always_comb begin
        do_ins    = 1'b0;
        do_del    = 1'b0;
        slot      = '0;
        op_status = ST_OK;
        unique case (op)
            OP_INS_FRONT: begin
                if (is_full) op_status = ST_FULL;
                else         do_ins    = 1'b1;
            end
            OP_INS_BACK: begin
                slot = r_count;
                if (is_full) op_status = ST_FULL;
                else         do_ins    = 1'b1;
            end
            OP_INS_AT: begin
                slot = pos_ext;
                if (is_empty || (i_position > r_count)) op_status = ST_BADPOS;
                else if (is_full)                       op_status = ST_FULL;
                else                                    do_ins    = 1'b1;
            end
            OP_DEL_FRONT: begin
                if (is_empty) op_status = ST_EMPTY;
                else          do_del    = 1'b1;
            end
            OP_DEL_BACK: begin
                slot = last_slot;
                if (is_empty) op_status = ST_EMPTY;
                else          do_del    = 1'b1;
            end
            OP_DEL_AT: begin
                slot = pos_ext - CNT_W'(1);
                if (is_empty) op_status = ST_EMPTY;
                else if ((i_position == '0) || (i_position > r_count))
                    op_status = ST_BADPOS;
                else
                    do_del = 1'b1;
            end
            OP_SEARCH: begin
                if (is_empty) op_status = ST_EMPTY;
            end
            OP_DUMP: begin
                if (is_empty) op_status = ST_EMPTY;
            end
            default: op_status = ST_OK;
        endcase
        if (!accept) begin
            do_ins = 1'b0;
            do_del = 1'b0;
        end
    end

    // dump sequencing: first beat on accept, rest while busy
    assign dump_beat = (accept && (op == OP_DUMP) && !is_empty) || r_dump;
    assign beat_idx  = r_dump ? r_idx : '0;
    assign beat_last = (beat_idx == last_slot);

    // broadcast to the cells
    assign cell_bus.load_value = i_data_value;
    assign cell_bus.key        = i_search_key;
    assign cell_bus.head       = cell_value[0];

    // per-cell command and the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        always_comb begin
            cell_mode[g] = CM_HOLD;
            if (dump_beat) begin
                // rotate towards the front, head wraps to the tail
                if (IDX < last_slot)       cell_mode[g] = CM_RIGHT;
                else if (IDX == last_slot) cell_mode[g] = CM_HEAD;
            end else if (do_ins) begin
                if (IDX == slot)                          cell_mode[g] = CM_LOAD;
                else if ((IDX > slot) && (IDX <= r_count)) cell_mode[g] = CM_LEFT;
            end else if (do_del) begin
                if ((IDX >= slot) && (IDX < last_slot)) cell_mode[g] = CM_RIGHT;
            end
        end

        if (g == 0) begin : g_first
            assign left_value = i_data_value;
        end else begin : g_mid
            assign left_value = cell_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (cell_mode[g]),
            .i_bus   (cell_bus),
            .i_left  (left_value),
            .i_right (right_value),
            .o_value (cell_value[g]),
            .o_match (cell_match[g])
        );
    end

    // next control state
    always_comb begin
        n_count = r_count;
        if (do_ins)      n_count = r_count + CNT_W'(1);
        else if (do_del) n_count = r_count - CNT_W'(1);
        n_dump   = dump_beat ? !beat_last : r_dump;
        n_idx    = dump_beat ? beat_idx + CNT_W'(1) : r_idx;
        n_strobe = accept || r_dump;
    end

    // next result beat
    always_comb begin
        n_status = op_status;
        n_found  = 1'b0;
        n_elem   = '0;
        n_last   = 1'b1;
        n_len    = LEN_W'(n_count);
        if (dump_beat) begin
            n_status = ST_OK;
            n_elem   = cell_value[0];
            n_last   = beat_last;
            n_len    = LEN_W'(r_count);
        end else if ((op == OP_SEARCH) && !is_empty) begin
            n_found = any_match;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_dump   <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_dump   <= n_dump;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_elem   <= n_elem;
            r_last   <= n_last;
            r_len    <= n_len;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_element_value = r_elem;
    assign o_last_item     = r_last;
    assign o_list_length   = r_len;

endmodule

// ===== hdl/ple_cell.sv =====
// ---------------------------------------------------------------------------
// ple_cell: one slot of the list
// Holds one element, takes its neighbour's value or new data on command and
// compares its element with the search key.
// ---------------------------------------------------------------------------
module ple_cell (
    input  logic                              i_clk,
    input  ple_pkg::t_cell_mode               i_mode,
    input  ple_pkg::t_cell_bus                i_bus,
    input  logic signed [ple_pkg::DATA_W-1:0] i_left,
    input  logic signed [ple_pkg::DATA_W-1:0] i_right,
    output logic signed [ple_pkg::DATA_W-1:0] o_value,
    output logic                              o_match
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    // next element
    always_comb begin
        unique case (i_mode)
            CM_LOAD:  n_value = i_bus.load_value;
            CM_LEFT:  n_value = i_left;
            CM_RIGHT: n_value = i_right;
            CM_HEAD:  n_value = i_bus.head;
            default:  n_value = r_value;
        endcase
    end

    // element storage, no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_bus.key);

endmodule

// ===== hdl/ple_checker.sv =====
// ---------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// Watches the command and result ports and flags beats that break the
// block's result framing.
// ---------------------------------------------------------------------------
module ple_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_strobe,
    input logic [ple_pkg::ST_W-1:0]          o_status,
    input logic                              o_found,
    input logic signed [ple_pkg::DATA_W-1:0] o_element_value,
    input logic                              o_last_item
);
    import ple_pkg::*;

    // every accepted operation shows a beat on the next cycle
    a_accept_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("no result beat after accepted operation");

    // dump beats run back to back until the last one
    a_dump_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_item) |=> o_strobe)
        else $error("gap inside dump");

    // busy holds while a dump still has beats to give
    a_dump_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_item) |-> busy)
        else $error("busy low in the middle of a dump");

    // a hit is a single ok beat
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> (o_status == ST_OK && o_last_item))
        else $error("found on a beat that is not a single ok beat");

    // an error beat is single and carries no element
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |->
            (o_last_item && !o_found && o_element_value == '0))
        else $error("error beat carries data");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_found         (o_found),
    .o_element_value (o_element_value),
    .o_last_item     (o_last_item)
);
